// ----- sv/prcf_pkg.sv -----
// prcf_pkg: shared constants, register map and drop reason codes for the
// point range / crop filter. No dependencies; compiled first.
package prcf_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int ATTR_W   = 32;
  localparam int RANGE_W  = 23;
  localparam int BOUNDS_W = 48;
  localparam int BOUND_W  = 24;
  // signed width that holds any coordinate or bound for comparison
  localparam int BOX_CMP_W = 32;

  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_RANGE_LO      = 3'd0,
    REG_RANGE_HI      = 3'd1,
    REG_CROP_ENABLE   = 3'd2,
    REG_CROP_X_BOUNDS = 3'd3,
    REG_CROP_Y_BOUNDS = 3'd4,
    REG_CROP_Z_BOUNDS = 3'd5
  } reg_idx_t;

  localparam logic [RANGE_W-1:0] RANGE_LO_RST = 23'd0;
  localparam logic [RANGE_W-1:0] RANGE_HI_RST = 23'd100000;

  typedef enum logic [1:0] {
    REASON_KEPT    = 2'd0,
    REASON_INVALID = 2'd1,
    REASON_RANGE   = 2'd2,
    REASON_BODY    = 2'd3
  } drop_reason_t;

endpackage

// ----- sv/prcf_if.sv -----
// prcf_in_if / prcf_out_if: valid/ready point channels into and out of the
// point range / crop filter. Depends on prcf_pkg.
interface prcf_in_if
  import prcf_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          first_of_scan;
  logic                          coords_valid;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  logic [ATTR_W-1:0]             attribute;

  modport source (output valid, first_of_scan, coords_valid, pos_x, pos_y, pos_z,
                  attribute, input ready);
  modport sink (input valid, first_of_scan, coords_valid, pos_x, pos_y, pos_z,
                attribute, output ready);
endinterface

interface prcf_out_if
  import prcf_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          keep;
  logic [1:0]                    drop_reason;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic signed [COORD_WIDTH-1:0] out_z;
  logic [ATTR_W-1:0]             out_attribute;
  logic [COUNT_WIDTH-1:0]        input_count;
  logic [COUNT_WIDTH-1:0]        output_count;
  logic [COUNT_WIDTH-1:0]        invalid_count;
  logic [COUNT_WIDTH-1:0]        range_count;
  logic [COUNT_WIDTH-1:0]        body_count;

  modport source (output valid, keep, drop_reason, out_x, out_y, out_z, out_attribute,
                  input_count, output_count, invalid_count, range_count, body_count,
                  input ready);
  modport sink (input valid, keep, drop_reason, out_x, out_y, out_z, out_attribute,
                input_count, output_count, invalid_count, range_count, body_count,
                output ready);
endinterface

// ----- sv/point_range_crop_filter.sv -----
// point_range_crop_filter: keep/drop decision for 3D points by range and
// crop box, with per-scan saturating counters. Depends on prcf_pkg, prcf_if.
//
//   channel     kind        width / fields
//   point_in    valid/ready first_of_scan, coords_valid, pos_x/y/z, attribute
//   point_out   valid/ready keep, drop_reason, out_x/y/z, out_attribute, counts
//   apb         APB r/w     64-bit data, register i at byte address 8*i
//
// one word per cycle while the output is not stalled; each word goes through the
// input register, then the result register. the three coordinate squares, the
// distance add, the compares and the counter update sit between the two registers.
// rst is synchronous; it clears the counters, stage valids and config registers.
// a stalled output holds its word; the input register still takes a word if empty,
// then ready drops until the result moves.
module point_range_crop_filter
  import prcf_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  prcf_in_if.sink               point_in,
  prcf_out_if.source            point_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int SQ_W   = 2 * COORD_WIDTH;
  localparam int SUM_W  = SQ_W + 2;
  localparam int RSQ_W  = 2 * RANGE_W;
  localparam int CMP_W  = (SUM_W > RSQ_W) ? SUM_W : RSQ_W;

  // ---------------- configuration registers ----------------
  logic [RANGE_W-1:0]  range_lo;
  logic [RANGE_W-1:0]  range_hi;
  logic                crop_enable;
  logic [BOUNDS_W-1:0] crop_x_bounds;
  logic [BOUNDS_W-1:0] crop_y_bounds;
  logic [BOUNDS_W-1:0] crop_z_bounds;
  logic [RSQ_W-1:0]    range_lo_sq;
  logic [RSQ_W-1:0]    range_hi_sq;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // squared limits are refreshed together with each range write
  always_ff @(posedge clk) begin
    if (rst) begin
      range_lo      <= RANGE_LO_RST;
      range_hi      <= RANGE_HI_RST;
      range_lo_sq   <= RSQ_W'(RANGE_LO_RST) * RSQ_W'(RANGE_LO_RST);
      range_hi_sq   <= RSQ_W'(RANGE_HI_RST) * RSQ_W'(RANGE_HI_RST);
      crop_enable   <= 1'b0;
      crop_x_bounds <= '0;
      crop_y_bounds <= '0;
      crop_z_bounds <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RANGE_LO: begin
          range_lo    <= pwdata[RANGE_W-1:0];
          range_lo_sq <= RSQ_W'(pwdata[RANGE_W-1:0]) * RSQ_W'(pwdata[RANGE_W-1:0]);
        end
        REG_RANGE_HI: begin
          range_hi    <= pwdata[RANGE_W-1:0];
          range_hi_sq <= RSQ_W'(pwdata[RANGE_W-1:0]) * RSQ_W'(pwdata[RANGE_W-1:0]);
        end
        REG_CROP_ENABLE:   crop_enable   <= pwdata[0];
        REG_CROP_X_BOUNDS: crop_x_bounds <= pwdata[BOUNDS_W-1:0];
        REG_CROP_Y_BOUNDS: crop_y_bounds <= pwdata[BOUNDS_W-1:0];
        REG_CROP_Z_BOUNDS: crop_z_bounds <= pwdata[BOUNDS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RANGE_LO:      prdata = APB_DATA_W'(range_lo);
      REG_RANGE_HI:      prdata = APB_DATA_W'(range_hi);
      REG_CROP_ENABLE:   prdata = APB_DATA_W'(crop_enable);
      REG_CROP_X_BOUNDS: prdata = APB_DATA_W'(crop_x_bounds);
      REG_CROP_Y_BOUNDS: prdata = APB_DATA_W'(crop_y_bounds);
      REG_CROP_Z_BOUNDS: prdata = APB_DATA_W'(crop_z_bounds);
      default:           prdata = '0;
    endcase
  end

  // ---------------- helpers ----------------
  function automatic logic signed [BOX_CMP_W-1:0] bound_lo(logic [BOUNDS_W-1:0] b);
    return BOX_CMP_W'($signed(b[BOUND_W-1:0]));
  endfunction

  function automatic logic signed [BOX_CMP_W-1:0] bound_hi(logic [BOUNDS_W-1:0] b);
    return BOX_CMP_W'($signed(b[BOUNDS_W-1:BOUND_W]));
  endfunction

  function automatic logic axis_in(logic [BOUNDS_W-1:0] b,
                                   logic signed [COORD_WIDTH-1:0] v);
    logic signed [BOX_CMP_W-1:0] ve;
    ve = BOX_CMP_W'(v);
    return (bound_lo(b) <= ve) && (ve <= bound_hi(b));
  endfunction

  function automatic logic [COORD_WIDTH-1:0] mag(logic signed [COORD_WIDTH-1:0] v);
    return v[COORD_WIDTH-1] ? COORD_WIDTH'(-v) : COORD_WIDTH'(v);
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(logic [COUNT_WIDTH-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  // ---------------- input register ----------------
  logic                          a_vld;
  logic                          a_first;
  logic                          a_coords_ok;
  logic signed [COORD_WIDTH-1:0] a_x, a_y, a_z;
  logic [ATTR_W-1:0]             a_attr;

  // ---------------- result register ----------------
  logic c_vld;
  logic a_ready, c_ready;

  assign c_ready        = !c_vld || point_out.ready;
  assign a_ready        = !a_vld || c_ready;
  assign point_in.ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (a_ready) begin
      a_vld <= point_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_first     <= point_in.first_of_scan;
      a_coords_ok <= point_in.coords_valid;
      a_x         <= point_in.pos_x;
      a_y         <= point_in.pos_y;
      a_z         <= point_in.pos_z;
      a_attr      <= point_in.attribute;
    end
  end

  // decision for the word in the input register
  logic [SQ_W-1:0]  sq_x, sq_y, sq_z;
  logic             in_box;
  logic [SUM_W-1:0] dist_sq;
  logic [CMP_W-1:0] dist_cmp;
  logic             range_bad;
  logic             box_bad;
  drop_reason_t     reason;

  assign sq_x      = SQ_W'(mag(a_x)) * SQ_W'(mag(a_x));
  assign sq_y      = SQ_W'(mag(a_y)) * SQ_W'(mag(a_y));
  assign sq_z      = SQ_W'(mag(a_z)) * SQ_W'(mag(a_z));
  assign in_box    = crop_enable && axis_in(crop_x_bounds, a_x)
                     && axis_in(crop_y_bounds, a_y) && axis_in(crop_z_bounds, a_z);
  assign dist_sq   = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
  assign dist_cmp  = CMP_W'(dist_sq);
  assign range_bad = range_hi < range_lo;
  assign box_bad   = (bound_lo(crop_x_bounds) > bound_hi(crop_x_bounds))
                  || (bound_lo(crop_y_bounds) > bound_hi(crop_y_bounds))
                  || (bound_lo(crop_z_bounds) > bound_hi(crop_z_bounds));

  always_comb begin
    priority if (!a_coords_ok) begin
      reason = REASON_INVALID;
    end else if (range_bad) begin
      reason = REASON_RANGE;
    end else if (crop_enable && box_bad) begin
      reason = REASON_BODY;
    end else if (dist_cmp < CMP_W'(range_lo_sq) || dist_cmp > CMP_W'(range_hi_sq)) begin
      reason = REASON_RANGE;
    end else if (in_box) begin
      reason = REASON_BODY;
    end else begin
      reason = REASON_KEPT;
    end
  end

  // counters live in the result register; first of scan restarts from zero
  logic [COUNT_WIDTH-1:0] seen_base, kept_base, invalid_base, range_base, body_base;

  assign seen_base    = a_first ? '0 : point_out.input_count;
  assign kept_base    = a_first ? '0 : point_out.output_count;
  assign invalid_base = a_first ? '0 : point_out.invalid_count;
  assign range_base   = a_first ? '0 : point_out.range_count;
  assign body_base    = a_first ? '0 : point_out.body_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld                   <= 1'b0;
      point_out.input_count   <= '0;
      point_out.output_count  <= '0;
      point_out.invalid_count <= '0;
      point_out.range_count   <= '0;
      point_out.body_count    <= '0;
    end else if (c_ready) begin
      c_vld <= a_vld;
      if (a_vld) begin
        point_out.input_count   <= sat_inc(seen_base);
        point_out.output_count  <= (reason == REASON_KEPT) ? sat_inc(kept_base) : kept_base;
        point_out.invalid_count <= (reason == REASON_INVALID) ? sat_inc(invalid_base)
                                                              : invalid_base;
        point_out.range_count   <= (reason == REASON_RANGE) ? sat_inc(range_base)
                                                            : range_base;
        point_out.body_count    <= (reason == REASON_BODY) ? sat_inc(body_base) : body_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && a_vld) begin
      point_out.keep          <= (reason == REASON_KEPT);
      point_out.drop_reason   <= reason;
      point_out.out_x         <= a_x;
      point_out.out_y         <= a_y;
      point_out.out_z         <= a_z;
      point_out.out_attribute <= a_attr;
    end
  end

  assign point_out.valid = c_vld;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// testbench for point_range_crop_filter: directed and random points and APB register
// settings, every result checked against a built-in keep/drop and counter predictor.
// Depends on prcf_pkg, the channel interfaces in prcf_if and the filter RTL.

module testbench;
  import prcf_pkg::*;

  localparam int COORD_W = COORD_WIDTH_DEF;
  localparam int COUNT_W = COUNT_WIDTH_DEF;
  localparam int NUM_REGS = 6;
  localparam longint COORD_HI = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint COORD_LO = -(longint'(1) << (COORD_W - 1));
  localparam longint RANGE_TOP = (longint'(1) << RANGE_W) - 1;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 6;
  localparam int MAX_REPORTS = 40;
  localparam int SEGMENTS = 6;
  localparam int SEGMENT_POINTS = 100;

  typedef struct {
    logic                      first_of_scan;
    logic                      coords_valid;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [ATTR_W-1:0]         attribute;
  } point_word_t;

  typedef struct {
    logic                      keep;
    logic [1:0]                reason;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [ATTR_W-1:0]         attribute;
    logic [COUNT_W-1:0]        n_seen;
    logic [COUNT_W-1:0]        n_kept;
    logic [COUNT_W-1:0]        n_invalid;
    logic [COUNT_W-1:0]        n_range;
    logic [COUNT_W-1:0]        n_body;
  } filter_result_t;

  class crop_filter_scoreboard;
    logic [RANGE_W-1:0]  range_lo;
    logic [RANGE_W-1:0]  range_hi;
    logic                crop_on;
    logic [BOUNDS_W-1:0] box_x;
    logic [BOUNDS_W-1:0] box_y;
    logic [BOUNDS_W-1:0] box_z;
    logic [COUNT_W-1:0]  n_seen;
    logic [COUNT_W-1:0]  n_kept;
    logic [COUNT_W-1:0]  n_invalid;
    logic [COUNT_W-1:0]  n_range;
    logic [COUNT_W-1:0]  n_body;
    filter_result_t      expected_results[$];
    int                  errors;
    int                  checked;
    int                  reason_hits[4];

    function new();
      range_lo = RANGE_LO_RST;
      range_hi = RANGE_HI_RST;
      crop_on = 1'b0;
      box_x = '0;
      box_y = '0;
      box_z = '0;
      n_seen = '0;
      n_kept = '0;
      n_invalid = '0;
      n_range = '0;
      n_body = '0;
      errors = 0;
      checked = 0;
      reason_hits = '{default: 0};
    endfunction

    function void set_register(int idx, logic [APB_DATA_W-1:0] value);
      case (idx)
        REG_RANGE_LO:      range_lo = value[RANGE_W-1:0];
        REG_RANGE_HI:      range_hi = value[RANGE_W-1:0];
        REG_CROP_ENABLE:   crop_on = value[0];
        REG_CROP_X_BOUNDS: box_x = value[BOUNDS_W-1:0];
        REG_CROP_Y_BOUNDS: box_y = value[BOUNDS_W-1:0];
        REG_CROP_Z_BOUNDS: box_z = value[BOUNDS_W-1:0];
        default: ;  // unmapped index leaves everything alone
      endcase
    endfunction

    function bit axis_ok(logic [BOUNDS_W-1:0] b);
      return $signed(b[BOUND_W-1:0]) <= $signed(b[BOUNDS_W-1:BOUND_W]);
    endfunction

    function bit axis_in(logic [BOUNDS_W-1:0] b, logic signed [COORD_W-1:0] v);
      return $signed(b[BOUND_W-1:0]) <= v && v <= $signed(b[BOUNDS_W-1:BOUND_W]);
    endfunction

    function logic [COUNT_W-1:0] sat_bump(logic [COUNT_W-1:0] c);
      return (&c) ? c : c + 1'b1;
    endfunction

    function void note_point(point_word_t p);
      filter_result_t r;
      drop_reason_t   why;
      longint         d2;
      longint         lim_lo;
      longint         lim_hi;
      bit             box_ok;
      d2 = longint'(p.x) * longint'(p.x) + longint'(p.y) * longint'(p.y) +
           longint'(p.z) * longint'(p.z);
      lim_lo = longint'(range_lo) * longint'(range_lo);
      lim_hi = longint'(range_hi) * longint'(range_hi);
      box_ok = axis_ok(box_x) && axis_ok(box_y) && axis_ok(box_z);
      if (!p.coords_valid) begin
        why = REASON_INVALID;
      end else if (range_hi < range_lo) begin
        why = REASON_RANGE;
      end else if (crop_on && !box_ok) begin
        why = REASON_BODY;
      end else if (d2 < lim_lo || d2 > lim_hi) begin
        why = REASON_RANGE;
      end else if (crop_on && axis_in(box_x, p.x) && axis_in(box_y, p.y) &&
                   axis_in(box_z, p.z)) begin
        why = REASON_BODY;
      end else begin
        why = REASON_KEPT;
      end
      if (p.first_of_scan) begin
        n_seen = '0;
        n_kept = '0;
        n_invalid = '0;
        n_range = '0;
        n_body = '0;
      end
      n_seen = sat_bump(n_seen);
      case (why)
        REASON_KEPT:    n_kept = sat_bump(n_kept);
        REASON_INVALID: n_invalid = sat_bump(n_invalid);
        REASON_RANGE:   n_range = sat_bump(n_range);
        default:        n_body = sat_bump(n_body);
      endcase
      r.keep = (why == REASON_KEPT);
      r.reason = why;
      r.x = p.x;
      r.y = p.y;
      r.z = p.z;
      r.attribute = p.attribute;
      r.n_seen = n_seen;
      r.n_kept = n_kept;
      r.n_invalid = n_invalid;
      r.n_range = n_range;
      r.n_body = n_body;
      expected_results.insert(expected_results.size(), r);
      reason_hits[why]++;
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(filter_result_t got);
      filter_result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: word with no point pending, expected none got x %0d y %0d z %0d",
                   $time, got.x, got.y, got.z);
        return;
      end
      want = expected_results.pop_front();
      checked++;
      compare_field("keep", want.keep, got.keep);
      compare_field("drop_reason", want.reason, got.reason);
      compare_field("out_x", want.x, got.x);
      compare_field("out_y", want.y, got.y);
      compare_field("out_z", want.z, got.z);
      compare_field("out_attribute", want.attribute, got.attribute);
      compare_field("input_count", want.n_seen, got.n_seen);
      compare_field("output_count", want.n_kept, got.n_kept);
      compare_field("invalid_count", want.n_invalid, got.n_invalid);
      compare_field("range_count", want.n_range, got.n_range);
      compare_field("body_count", want.n_body, got.n_body);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  prcf_in_if #(.COORD_WIDTH(COORD_W)) point_in_bus ();
  prcf_out_if #(.COORD_WIDTH(COORD_W), .COUNT_WIDTH(COUNT_W)) point_out_bus ();

  point_range_crop_filter #(
    .COORD_WIDTH(COORD_W),
    .COUNT_WIDTH(COUNT_W)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .point_in (point_in_bus),
    .point_out(point_out_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  crop_filter_scoreboard sb;
  int             send_idle;
  int             recv_idle;
  int             quiet_cycles = 0;
  int             n_writes = 0;
  bit             in_fire = 1'b0;
  bit             out_fire = 1'b0;
  bit             apb_fire = 1'b0;
  point_word_t    in_seen;
  filter_result_t out_seen;

  always #1 clk = ~clk;

  // everything settles well before the falling edge, so handshakes are sampled there
  always @(negedge clk) begin
    in_fire = point_in_bus.valid === 1'b1 && point_in_bus.ready === 1'b1;
    out_fire = point_out_bus.valid === 1'b1 && point_out_bus.ready === 1'b1;
    apb_fire = psel && penable && pwrite && pready === 1'b1;
    in_seen.first_of_scan = point_in_bus.first_of_scan;
    in_seen.coords_valid = point_in_bus.coords_valid;
    in_seen.x = point_in_bus.pos_x;
    in_seen.y = point_in_bus.pos_y;
    in_seen.z = point_in_bus.pos_z;
    in_seen.attribute = point_in_bus.attribute;
    out_seen.keep = point_out_bus.keep;
    out_seen.reason = point_out_bus.drop_reason;
    out_seen.x = point_out_bus.out_x;
    out_seen.y = point_out_bus.out_y;
    out_seen.z = point_out_bus.out_z;
    out_seen.attribute = point_out_bus.out_attribute;
    out_seen.n_seen = point_out_bus.input_count;
    out_seen.n_kept = point_out_bus.output_count;
    out_seen.n_invalid = point_out_bus.invalid_count;
    out_seen.n_range = point_out_bus.range_count;
    out_seen.n_body = point_out_bus.body_count;
  end

  always @(posedge clk) begin
    if (in_fire) sb.note_point(in_seen);
    if (out_fire) sb.check_result(out_seen);
    if (in_fire || out_fire || apb_fire) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d points outstanding", $time,
               quiet_cycles, sb.expected_results.size());
      $display("point_range_crop_filter: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    point_out_bus.ready <= !rst && ($urandom_range(99) >= recv_idle);
  end

  function automatic longint clip_coord(longint v);
    if (v > COORD_HI) return COORD_HI;
    if (v < COORD_LO) return COORD_LO;
    return v;
  endfunction

  function automatic point_word_t pt(bit first, bit ok, longint x, longint y, longint z,
                                     logic [ATTR_W-1:0] attr);
    point_word_t p;
    p.first_of_scan = first;
    p.coords_valid = ok;
    p.x = COORD_W'(x);
    p.y = COORD_W'(y);
    p.z = COORD_W'(z);
    p.attribute = attr;
    return p;
  endfunction

  function automatic logic [BOUNDS_W-1:0] box_of(longint lo, longint hi);
    return {hi[BOUND_W-1:0], lo[BOUND_W-1:0]};
  endfunction

  // random bits above the register width, which the block has to drop
  function automatic logic [APB_DATA_W-1:0] with_junk(logic [APB_DATA_W-1:0] v, int w);
    logic [APB_DATA_W-1:0] junk;
    junk = {$urandom, $urandom};
    if ($urandom_range(1) == 0) return v;
    return v | (junk << w);
  endfunction

  function automatic logic [BOUNDS_W-1:0] random_box();
    longint lo;
    lo = longint'($urandom_range(6000)) - 3000;
    case ($urandom_range(9))
      0:       return box_of(COORD_LO, COORD_HI);
      1:       return box_of(lo, lo - 1 - longint'($urandom_range(500)));
      default: return box_of(lo, lo + longint'($urandom_range(4000)));
    endcase
  endfunction

  // coordinate on, just off or between the faces of one box axis
  function automatic longint near_face(logic [BOUNDS_W-1:0] b);
    longint lo;
    longint hi;
    lo = $signed(b[BOUND_W-1:0]);
    hi = $signed(b[BOUNDS_W-1:BOUND_W]);
    case ($urandom_range(4))
      0: return lo;
      1: return hi;
      2: return clip_coord(lo - 1);
      3: return clip_coord(hi + 1);
      default: return (lo <= hi) ? lo + longint'($urandom_range(int'(hi - lo))) : lo;
    endcase
  endfunction

  function automatic point_word_t random_point();
    point_word_t p;
    longint      c[3];
    longint      mag;
    int          pick;
    int          axis;
    pick = $urandom_range(99);
    for (int i = 0; i < 3; i++) c[i] = longint'($urandom_range(24000)) - 12000;
    if (pick < 25) begin
      for (int i = 0; i < 3; i++) c[i] = longint'($signed(COORD_W'($urandom)));
    end else if (pick < 45) begin
      // on an axis, at or one off a range limit
      axis = $urandom_range(2);
      mag = $urandom_range(1) ? longint'(sb.range_lo) : longint'(sb.range_hi);
      mag = mag + longint'($urandom_range(2)) - 1;
      for (int i = 0; i < 3; i++) c[i] = 0;
      c[axis] = clip_coord($urandom_range(1) ? -mag : mag);
    end else if (pick < 65) begin
      c[0] = near_face(sb.box_x);
      c[1] = near_face(sb.box_y);
      c[2] = near_face(sb.box_z);
    end
    p = pt($urandom_range(29) == 0, pick >= 10, c[0], c[1], c[2], $urandom);
    return p;
  endfunction

  task automatic send_point(point_word_t p);
    while ($urandom_range(99) < send_idle) begin
      point_in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    point_in_bus.valid <= 1'b1;
    point_in_bus.first_of_scan <= p.first_of_scan;
    point_in_bus.coords_valid <= p.coords_valid;
    point_in_bus.pos_x <= p.x;
    point_in_bus.pos_y <= p.y;
    point_in_bus.pos_z <= p.z;
    point_in_bus.attribute <= p.attribute;
    do @(posedge clk); while (!in_fire);
  endtask

  task automatic wait_drained();
    point_in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // registers only change with the pipeline empty
  task automatic reg_write(int idx, logic [APB_DATA_W-1:0] value);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(idx * 8);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!apb_fire);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.set_register(idx, value);
    n_writes++;
  endtask

  task automatic random_settings();
    longint lo_r;
    longint hi_r;
    case ($urandom_range(7))
      0: begin
        lo_r = 0;
        hi_r = RANGE_TOP;
      end
      1: begin
        lo_r = $urandom_range(6000, 3000);
        hi_r = $urandom_range(2999);
      end
      2: begin
        lo_r = $urandom_range(10000);
        hi_r = lo_r;
      end
      default: begin
        lo_r = $urandom_range(3000);
        hi_r = $urandom_range(15000, 3000);
      end
    endcase
    reg_write(REG_RANGE_LO, with_junk(lo_r, RANGE_W));
    reg_write(REG_RANGE_HI, with_junk(hi_r, RANGE_W));
    reg_write(REG_CROP_ENABLE, with_junk(APB_DATA_W'($urandom_range(3) != 0), 1));
    reg_write(REG_CROP_X_BOUNDS, with_junk(random_box(), BOUNDS_W));
    reg_write(REG_CROP_Y_BOUNDS, with_junk(random_box(), BOUNDS_W));
    reg_write(REG_CROP_Z_BOUNDS, with_junk(random_box(), BOUNDS_W));
  endtask

  task automatic run_directed();
    // reset settings: origin, invalid flag with extreme coords, exact max range
    send_point(pt(1, 1, 0, 0, 0, 32'h0000_0000));
    send_point(pt(0, 0, COORD_LO, COORD_LO, COORD_LO, 32'hffff_ffff));
    send_point(pt(0, 1, 100000, 0, 0, 32'h1234_5678));
    send_point(pt(0, 1, 0, -100001, 0, 32'h8000_0001));
    send_point(pt(0, 1, COORD_HI, COORD_LO, COORD_HI, 32'h5a5a_a5a5));
    // 1000..5000 mm ring, inverted x box ignored while cropping is off
    reg_write(REG_RANGE_LO, 1000);
    reg_write(REG_RANGE_HI, 5000);
    reg_write(REG_CROP_X_BOUNDS, box_of(10, -10));
    send_point(pt(0, 1, 600, 800, 0, $urandom));
    send_point(pt(0, 1, 600, 799, 0, $urandom));
    send_point(pt(0, 1, 0, -3000, 4000, $urandom));
    send_point(pt(0, 1, 0, 3000, 4001, $urandom));
    // broken box with cropping on
    reg_write(REG_CROP_ENABLE, 1);
    send_point(pt(0, 1, 2000, 0, 0, $urandom));
    send_point(pt(0, 0, 2000, 0, 0, $urandom));
    // crossed range limits outrank the broken box
    reg_write(REG_RANGE_LO, 5000);
    reg_write(REG_RANGE_HI, 1000);
    send_point(pt(0, 1, 2000, 0, 0, $urandom));
    reg_write(NUM_REGS, '1);
    reg_write(NUM_REGS + 1, '1);
    reg_write(REG_RANGE_LO, 0);
    reg_write(REG_RANGE_HI, RANGE_TOP);
    reg_write(REG_CROP_X_BOUNDS, box_of(-100, 100));
    reg_write(REG_CROP_Y_BOUNDS, box_of(-200, 200));
    reg_write(REG_CROP_Z_BOUNDS, box_of(-50, 50));
    // faces count as inside
    send_point(pt(1, 1, 100, 200, 50, $urandom));
    send_point(pt(0, 1, -100, -200, -50, $urandom));
    send_point(pt(0, 1, 101, 0, 0, $urandom));
    send_point(pt(0, 1, 0, -201, 0, $urandom));
    send_point(pt(0, 1, 0, 0, 0, $urandom));
    send_point(pt(0, 1, COORD_HI, 0, 0, $urandom));
    send_point(pt(0, 1, COORD_LO, 0, 0, $urandom));
    // single-distance ring at the top of the range
    reg_write(REG_RANGE_LO, RANGE_TOP);
    reg_write(REG_CROP_ENABLE, 0);
    send_point(pt(0, 1, 0, -COORD_HI, 0, $urandom));
    send_point(pt(0, 1, 0, 0, COORD_HI - 1, $urandom));
  endtask

  initial begin
    int idle_plan[3][2];
    idle_plan = '{'{19, 81}, '{81, 19}, '{0, 0}};
    sb = new();
    send_idle = 0;
    recv_idle = 0;
    point_in_bus.valid = 1'b0;
    point_in_bus.first_of_scan = 1'b0;
    point_in_bus.coords_valid = 1'b0;
    point_in_bus.pos_x = '0;
    point_in_bus.pos_y = '0;
    point_in_bus.pos_z = '0;
    point_in_bus.attribute = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = idle_plan[ph][0];
      recv_idle = idle_plan[ph][1];
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        random_settings();
        repeat (SEGMENT_POINTS) send_point(random_point());
      end
    end
    wait_drained();
    $display("checked %0d points across %0d register writes and three idle patterns",
             sb.checked, n_writes);
    $display("outcomes: %0d kept, %0d invalid, %0d out of range, %0d in crop box",
             sb.reason_hits[REASON_KEPT], sb.reason_hits[REASON_INVALID],
             sb.reason_hits[REASON_RANGE], sb.reason_hits[REASON_BODY]);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("point_range_crop_filter: match");
    end else begin
      $display("point_range_crop_filter: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/prcf_pkg.sv
sv/prcf_if.sv
sv/point_range_crop_filter.sv
bench/testbench.sv
